// ===== rtl/kmsf_pkg.sv =====
// Shared types and constants for the key matrix scanner with key FIFO.
// No dependencies; imported by the interfaces, the scanner and the top level.
`default_nettype none

package kmsf_pkg;

    localparam int MATRIX_W = 64;
    localparam int CODE_W   = 7;

    typedef logic [5:0]          t_key_idx;
    typedef logic [CODE_W-1:0]   t_code;
    typedef logic [MATRIX_W-1:0] t_matrix;

    localparam t_key_idx KEY_LSHIFT = 6'd15;
    localparam t_key_idx KEY_RSHIFT = 6'd52;
    localparam t_key_idx KEY_CTRL   = 6'd58;
    localparam t_key_idx KEY_LOGO   = 6'd61;
    localparam t_key_idx KEY_LAST   = 6'd63;

    localparam t_code CHAR_LOWER_A = 7'h61;
    localparam t_code CHAR_LOWER_Z = 7'h7A;
    localparam t_code CASE_OFFSET  = 7'h20;
    localparam t_code CODE_NONE    = 7'h00;

    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // ASCII per matrix position, row-major; zero marks an unmapped key
    localparam t_code KEY_TABLE [MATRIX_W] = '{
        7'h08, 7'h0D, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h33, 7'h77, 7'h61, 7'h34, 7'h7A, 7'h73, 7'h65, 7'h00,
        7'h35, 7'h72, 7'h64, 7'h36, 7'h63, 7'h66, 7'h74, 7'h78,
        7'h37, 7'h79, 7'h67, 7'h38, 7'h62, 7'h68, 7'h75, 7'h76,
        7'h39, 7'h69, 7'h6A, 7'h30, 7'h6D, 7'h6B, 7'h6F, 7'h6E,
        7'h2B, 7'h70, 7'h6C, 7'h2D, 7'h2E, 7'h3A, 7'h40, 7'h2C,
        7'h00, 7'h2A, 7'h3B, 7'h00, 7'h00, 7'h3D, 7'h00, 7'h2F,
        7'h31, 7'h00, 7'h00, 7'h32, 7'h20, 7'h00, 7'h71, 7'h00
    };

    typedef struct packed {
        logic  valid;
        t_code code;
    } t_push;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_READ   = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/kmsf_if.sv =====
// Valid/ready channel interfaces for snapshot input and key output.
// Depends on kmsf_pkg.
`default_nettype none

interface kmsf_in_if import kmsf_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    opcode;
    t_matrix matrix;

    modport source (output valid, output opcode, output matrix, input ready);
    modport sink   (input valid, input opcode, input matrix, output ready);
endinterface

interface kmsf_out_if import kmsf_pkg::*; ();
    logic  valid;
    logic  ready;
    t_code key_code;
    logic  key_valid;

    modport source (output valid, output key_code, output key_valid, input ready);
    modport sink   (input valid, input key_code, input key_valid, output ready);
endinterface

`default_nettype wire

// ===== rtl/kmsf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kmsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/kmsf_scan.sv =====
// Snapshot scanner: keeps the previous matrix and walks the new presses,
// one matrix position per cycle, producing FIFO push requests. Uses kmsf_pkg.
`default_nettype none

module kmsf_scan import kmsf_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_matrix i_matrix,
    output t_push        o_push,
    output logic         o_last
);

    t_matrix  r_prev;
    t_matrix  r_fresh;
    logic     r_shift;
    logic     r_busy;
    t_key_idx r_idx;
    t_code    w_code;
    logic     w_modifier;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '1;
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_start) begin
            // active low: a fresh press was high last time and is low now
            r_fresh <= r_prev & ~i_matrix;
            r_shift <= !i_matrix[KEY_LSHIFT] || !i_matrix[KEY_RSHIFT];
            r_prev  <= i_matrix;
            r_idx   <= '0;
            r_busy  <= 1'b1;
        end else if (r_busy) begin
            r_idx <= r_idx + 6'd1;
            if (r_idx == KEY_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        w_code     = KEY_TABLE[r_idx];
        w_modifier = (r_idx == KEY_LSHIFT) || (r_idx == KEY_RSHIFT) ||
                     (r_idx == KEY_CTRL) || (r_idx == KEY_LOGO);
        o_push.valid = r_busy && r_fresh[r_idx] && !w_modifier && (w_code != CODE_NONE);
        if (r_shift && (w_code >= CHAR_LOWER_A) && (w_code <= CHAR_LOWER_Z)) begin
            o_push.code = w_code - CASE_OFFSET;
        end else begin
            o_push.code = w_code;
        end
        o_last = r_busy && (r_idx == KEY_LAST);
    end

endmodule

`default_nettype wire

// ===== rtl/key_matrix_scanner_fifo_core.sv =====
// Key matrix scanner with key FIFO. Each input beat carries one 8x8 active-low
// matrix snapshot; newly pressed keys are walked one matrix position per cycle,
// mapped to ASCII (uppercased when a shift key is down) and pushed into a
// FIFO held in a RAM; pushes to a full FIFO are dropped. A pop beat scans and
// then reads one code (key_valid 0, key_code 0 when empty). A scan-only
// beat ends after the position walk; a pop beat adds the registered RAM read
// and waits for a free output register. The next beat is taken once the last
// one finishes, while an earlier result may still wait in the output register.
// Depends on kmsf_pkg, kmsf_if, kmsf_ram and kmsf_scan.
`default_nettype none

module key_matrix_scanner_fifo_core import kmsf_pkg::*; #(
    parameter int FIFO_DEPTH = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    kmsf_in_if.sink    i_in,
    kmsf_out_if.source o_out
);

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_state        r_state, n_state;
    logic          r_opcode;
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;
    logic          r_empty;
    logic          r_out_valid, n_out_valid;
    t_code         r_out_code;
    logic          r_out_kv;

    logic  w_accept;
    logic  w_push_ok;
    logic  w_pop_rd;
    logic  w_load;
    t_push w_push;
    logic  w_last;
    t_code w_rd_data;

    assign w_accept  = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    kmsf_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_matrix (i_in.matrix),
        .o_push   (w_push),
        .o_last   (w_last)
    );

    // writes happen only while scanning and the read only after, so no
    // same-entry overlap is possible
    kmsf_ram #(
        .WIDTH (CODE_W),
        .DEPTH (FIFO_DEPTH),
        .AW    (PW)
    ) u_fifo_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_push_ok),
        .i_wr_addr (r_wptr),
        .i_wr_data (w_push.code),
        .i_rd_en   (w_pop_rd),
        .i_rd_addr (r_rptr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        w_push_ok = w_push.valid && (r_count < CW'(FIFO_DEPTH));
        w_pop_rd  = (r_state == S_READ) && (r_count != '0);
        w_load    = (r_state == S_RESULT) && (!r_out_valid || o_out.ready);

        n_state = r_state;
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;

        if (w_push_ok) begin
            n_wptr  = (r_wptr == PW'(FIFO_DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            n_count = r_count + CW'(1);
        end else if (w_pop_rd) begin
            n_rptr  = (r_rptr == PW'(FIFO_DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            n_count = r_count - CW'(1);
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_last) begin
                    n_state = (r_opcode == OP_POP) ? S_READ : S_IDLE;
                end
            end
            S_READ: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wptr      <= n_wptr;
            r_rptr      <= n_rptr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_opcode <= i_in.opcode;
        end
        if (r_state == S_READ) begin
            r_empty <= (r_count == '0);
        end
        if (w_load) begin
            r_out_code <= r_empty ? CODE_NONE : w_rd_data;
            r_out_kv   <= !r_empty;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.key_code  = r_out_code;
    assign o_out.key_valid = r_out_kv;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(FIFO_DEPTH))
        else $error("fill count above FIFO depth");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((int'(r_wptr) - int'(r_rptr) + FIFO_DEPTH) % FIFO_DEPTH) ==
        (int'(r_count) % FIFO_DEPTH))
        else $error("pointer distance disagrees with fill count");

    a_push_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> (r_state == S_SCAN))
        else $error("push request outside the scan");

    a_scan_only_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_last && r_opcode == OP_SCAN) |=> (r_state == S_IDLE))
        else $error("scan-only beat did not return to idle");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for key_matrix_scanner_fifo_core: directed and random matrix snapshots,
// with a scoreboard predictor of the key FIFO. Depends on kmsf_pkg, kmsf_if and the core RTL.
`timescale 1ns / 100ps

module tb_top;
    import kmsf_pkg::*;

    localparam int  KEY_FIFO_DEPTH = 8;
    localparam int  RANDOM_SNAPS   = 1225;
    localparam int  TAIL_CYCLES    = 80;
    localparam int  LIMIT_CYCLES   = 1_000_000;
    localparam int  LONG_HOLD      = 800;
    localparam int  HOLD_AFTER     = 300;

    typedef struct {
        logic    opcode;
        t_matrix matrix;
        bit      drain;   // wait for all pending keys before offering this beat
    } t_snapshot;

    typedef struct {
        t_code code;
        logic  hit;
    } t_key_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    kmsf_in_if  snap_ch ();
    kmsf_out_if key_ch ();

    key_matrix_scanner_fifo_core #(
        .FIFO_DEPTH (KEY_FIFO_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (snap_ch),
        .o_out   (key_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow of the scanner state
    t_matrix     shadow_prev = '1;
    t_code       shadow_fifo[$];
    t_key_result exp_keys[$];

    t_snapshot   snapshot_q[$];
    t_snapshot   cur_snap;
    int          err_cnt     = 0;
    int          cycle_cnt   = 0;
    int          snaps_total = 0;
    int          snaps_sent  = 0;

    task automatic scan_and_pop(input t_snapshot s);
        t_matrix     fresh;
        bit          shifted;
        t_code       c;
        t_key_result r;
        fresh   = shadow_prev & ~s.matrix;
        shifted = !s.matrix[KEY_LSHIFT] || !s.matrix[KEY_RSHIFT];
        for (int i = 0; i < MATRIX_W; i++) begin
            if (!fresh[i]) continue;
            if (i == KEY_LSHIFT || i == KEY_RSHIFT || i == KEY_CTRL || i == KEY_LOGO) continue;
            c = KEY_TABLE[i];
            if (c == CODE_NONE) continue;
            if (shifted && c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) c = c - CASE_OFFSET;
            // full FIFO drops the push
            if (shadow_fifo.size() < KEY_FIFO_DEPTH) shadow_fifo.push_back(c);
        end
        shadow_prev = s.matrix;
        if (s.opcode == OP_POP) begin
            if (shadow_fifo.size() == 0) begin
                r.code = CODE_NONE;
                r.hit  = 1'b0;
            end else begin
                r.code = shadow_fifo.pop_front();
                r.hit  = 1'b1;
            end
            exp_keys.push_back(r);
        end
    endtask

    task automatic add_snapshot(input logic op, input t_matrix pressed, input bit drain);
        t_snapshot s;
        s.opcode = op;
        s.matrix = ~pressed;
        s.drain  = drain;
        snapshot_q.push_back(s);
    endtask

    // Sender: bursts of beats separated by random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            snap_ch.valid <= 1'b0;
        end else if (!(snap_ch.valid && !snap_ch.ready)) begin
            if (snap_ch.valid) begin
                scan_and_pop(cur_snap);
                snaps_sent++;
            end
            if (gap_left > 0) begin
                gap_left--;
                snap_ch.valid <= 1'b0;
            end else if (snapshot_q.size() != 0 &&
                         !(snapshot_q[0].drain && exp_keys.size() != 0)) begin
                cur_snap = snapshot_q.pop_front();
                snap_ch.valid  <= 1'b1;
                snap_ch.opcode <= cur_snap.opcode;
                snap_ch.matrix <= cur_snap.matrix;
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 8);
                    gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 120)
                                                            : $urandom_range(0, 3);
                end
            end else begin
                snap_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: rotating stall pattern, plus one long hold to back up the core
    logic [15:0] stall_pat = '1;
    int          pat_age   = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          keys_seen = 0;
    t_key_result want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_ch.ready <= 1'b0;
        end else begin
            if (key_ch.valid && key_ch.ready) begin
                keys_seen++;
                if (exp_keys.size() == 0) begin
                    $error("unexpected key beat: key_code %0h key_valid %0b",
                           key_ch.key_code, key_ch.key_valid);
                    err_cnt++;
                end else begin
                    want = exp_keys.pop_front();
                    if (key_ch.key_code !== want.code) begin
                        $error("key_code mismatch: expected %0h, got %0h",
                               want.code, key_ch.key_code);
                        err_cnt++;
                    end
                    if (key_ch.key_valid !== want.hit) begin
                        $error("key_valid mismatch: expected %0b, got %0b",
                               want.hit, key_ch.key_valid);
                        err_cnt++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                key_ch.ready <= 1'b0;
            end else if (!hold_done && keys_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                key_ch.ready <= 1'b0;
            end else begin
                if (pat_age == 0) begin
                    pat_age = 200;
                    case ($urandom_range(0, 3))
                        0: stall_pat = '1;
                        1: stall_pat = 16'($urandom);
                        2: stall_pat = 16'($urandom | $urandom);
                        default: stall_pat = 16'($urandom & $urandom);
                    endcase
                    if (stall_pat == '0) stall_pat[0] = 1'b1;
                end
                pat_age--;
                key_ch.ready <= stall_pat[0];
                stall_pat = {stall_pat[14:0], stall_pat[15]};
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_matrix held;
        t_matrix pressed;
        int      pop_pct;
        int      kind;
        logic    op;

        snap_ch.valid  = 1'b0;
        snap_ch.opcode = OP_SCAN;
        snap_ch.matrix = '1;
        key_ch.ready   = 1'b0;
        i_rst_n        = 1'b0;

        // directed: empty pop, plain and shifted keys, modifiers, overflow, drain
        add_snapshot(OP_POP,  64'd0, 1'b0);
        add_snapshot(OP_SCAN, 64'd1 << 10, 1'b0);
        add_snapshot(OP_POP,  64'd0, 1'b0);
        add_snapshot(OP_SCAN, (64'd1 << KEY_LSHIFT) | (64'd1 << 8) | (64'd1 << 9), 1'b0);
        add_snapshot(OP_SCAN, 64'd0, 1'b0);
        pressed = (64'd1 << KEY_RSHIFT) | (64'd1 << 62) | (64'd1 << 49);
        add_snapshot(OP_SCAN, pressed, 1'b0);
        add_snapshot(OP_POP,  pressed, 1'b0);
        add_snapshot(OP_POP,  64'd0, 1'b0);
        // modifiers and unmapped keys alone push nothing
        pressed = (64'd1 << KEY_CTRL) | (64'd1 << KEY_LOGO) | (64'd1 << 2) |
                  (64'd1 << KEY_LAST);
        add_snapshot(OP_SCAN, pressed, 1'b0);
        add_snapshot(OP_POP,  pressed, 1'b0);
        add_snapshot(OP_POP,  pressed, 1'b0);
        add_snapshot(OP_POP,  pressed, 1'b0);
        // every key down at once: FIFO fills, the rest is dropped
        add_snapshot(OP_SCAN, '1, 1'b0);
        for (int i = 0; i < 10; i++) add_snapshot(OP_POP, '1, 1'b0);
        add_snapshot(OP_SCAN, 64'd0, 1'b1);
        // new keys and pop in one beat: scan happens first
        add_snapshot(OP_POP, (64'd1 << 0) | (64'd1 << 1) | (64'd1 << 12), 1'b1);

        held    = '0;
        pop_pct = 60;
        for (int n = 0; n < RANDOM_SNAPS; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0: pop_pct = 25;
                    1: pop_pct = 60;
                    default: pop_pct = 95;
                endcase
            end
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                // typing: release some keys, press a few more, shift now and then
                held = held & {$urandom, $urandom};
                repeat ($urandom_range(0, 3)) held[$urandom_range(0, MATRIX_W - 1)] = 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    if ($urandom_range(0, 1) == 0) held[KEY_LSHIFT] = 1'b1;
                    else held[KEY_RSHIFT] = 1'b1;
                end
            end else if (kind < 80) begin
                held = '0;
            end else if (kind < 90) begin
                held = {$urandom, $urandom};
            end
            op = ($urandom_range(0, 99) < pop_pct) ? OP_POP : OP_SCAN;
            add_snapshot(op, held, (n % 150) == 149);
        end
        snaps_total = snapshot_q.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (snaps_sent < snaps_total) @(posedge i_clk);
        while (exp_keys.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== key_matrix_scanner_fifo_core.f =====
rtl/kmsf_pkg.sv
rtl/kmsf_if.sv
rtl/kmsf_ram.sv
rtl/kmsf_scan.sv
rtl/key_matrix_scanner_fifo_core.sv
tb/tb_top.sv
